// File: hw/rtl/srsk_pkg.sv
package srsk_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_BITS_DEF  = 16;
	localparam int KEY_W         = 16;
	localparam int TAG_W         = 16;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT_OUT
	} cell_op_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

// File: hw/rtl/srsk_cell.sv
module srsk_cell #(
	parameter int KEY_BITS = srsk_pkg::KEY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srsk_pkg::cell_op_t     op,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [srsk_pkg::TAG_W-1:0] new_tag,
	input  logic                   left_valid,
	input  logic [KEY_BITS-1:0]    left_key,
	input  logic [srsk_pkg::TAG_W-1:0] left_tag,
	input  logic                   left_gt,
	input  logic                   right_valid,
	input  logic [KEY_BITS-1:0]    right_key,
	input  logic [srsk_pkg::TAG_W-1:0] right_tag,
	output logic                   valid,
	output logic [KEY_BITS-1:0]    key,
	output logic [srsk_pkg::TAG_W-1:0] tag,
	output logic                   gt
);
	import srsk_pkg::*;

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TAG_W-1:0]    tag_q;

	// empty cells count as larger than any key; equal keys stay put
	assign gt    = !valid_q || (key_q > new_key);
	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				CELL_INSERT: begin
					if (gt) begin
						valid_q <= left_gt ? left_valid : 1'b1;
					end
				end
				CELL_SHIFT_OUT: begin
					valid_q <= right_valid;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_INSERT: begin
				if (gt) begin
					key_q <= left_gt ? left_key : new_key;
					tag_q <= left_gt ? left_tag : new_tag;
				end
			end
			CELL_SHIFT_OUT: begin
				key_q <= right_key;
				tag_q <= right_tag;
			end
			default: begin
				key_q <= key_q;
				tag_q <= tag_q;
			end
		endcase
	end

endmodule

// File: hw/rtl/stable_record_sort_by_key.sv
// Stable sorter for records of a key and a tag.
// Input channel: item_valid / item_stall with item_key, item_tag, item_last.
// A request is taken when item_valid is high and item_stall low. Records
// load into a chain of MAX_ITEMS sorted cells, one per cycle, each new
// record slotting in behind all held records of equal or smaller key.
// The request with item_last closes the batch. Records arriving while the
// chain is full are dropped and set out_overflow for the whole batch.
// Output channel: out_valid / out_stall with out_key, out_tag, out_last,
// out_overflow. After the closing request is taken, the drain state pops
// the chain head into the output register; then one result per cycle while
// out_stall is low, in ascending key order, equal keys in arrival order,
// out_last on the final one. Without output stalls the drain rate is set
// by popping the head of the cell chain.
// item_stall is high while the batch drains. While out_stall is high and a
// result is held, that result does not change and the chain waits.
// Reset empties the chain and the output register and clears overflow.
module stable_record_sort_by_key #(
	parameter int MAX_ITEMS = srsk_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS  = srsk_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [srsk_pkg::KEY_W-1:0]  item_key,
	input  logic [srsk_pkg::TAG_W-1:0]  item_tag,
	input  logic                        item_last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [srsk_pkg::KEY_W-1:0]  out_key,
	output logic [srsk_pkg::TAG_W-1:0]  out_tag,
	output logic                        out_last,
	output logic                        out_overflow
);
	import srsk_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic                overflow_q;
	logic                out_valid_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic                out_last_q;
	logic                out_overflow_q;

	logic                in_acc;
	logic                full;
	logic                pop;
	logic                last_pop;
	cell_op_t            op;
	logic [KEY_BITS-1:0] new_key;

	// slot 0 and slot MAX_ITEMS+1 are empty padding at both chain ends
	logic                c_valid [MAX_ITEMS+2];
	logic [KEY_BITS-1:0] c_key   [MAX_ITEMS+2];
	logic [TAG_W-1:0]    c_tag   [MAX_ITEMS+2];
	logic                c_gt    [MAX_ITEMS+2];
	logic [MAX_ITEMS-1:0] valid_vec;

	assign item_stall = (state_q == ST_DRAIN);
	assign in_acc     = item_valid && !item_stall;
	assign full       = (count_q == CNT_W'(MAX_ITEMS));
	assign pop        = (state_q == ST_DRAIN) && (count_q != '0)
	                    && (!out_valid_q || !out_stall);
	assign last_pop   = pop && (count_q == CNT_W'(1));
	assign new_key    = KEY_BITS'(item_key);

	always_comb begin
		priority if (in_acc && !full) begin
			op = CELL_INSERT;
		end else if (pop) begin
			op = CELL_SHIFT_OUT;
		end else begin
			op = CELL_HOLD;
		end
	end

	assign c_valid[0]           = 1'b0;
	assign c_key[0]             = '0;
	assign c_tag[0]             = '0;
	assign c_gt[0]              = 1'b0;
	assign c_valid[MAX_ITEMS+1] = 1'b0;
	assign c_key[MAX_ITEMS+1]   = '0;
	assign c_tag[MAX_ITEMS+1]   = '0;
	assign c_gt[MAX_ITEMS+1]    = 1'b0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		srsk_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.new_key    (new_key),
			.new_tag    (item_tag),
			.left_valid (c_valid[i]),
			.left_key   (c_key[i]),
			.left_tag   (c_tag[i]),
			.left_gt    (c_gt[i]),
			.right_valid(c_valid[i+2]),
			.right_key  (c_key[i+2]),
			.right_tag  (c_tag[i+2]),
			.valid      (c_valid[i+1]),
			.key        (c_key[i+1]),
			.tag        (c_tag[i+1]),
			.gt         (c_gt[i+1])
		);
		assign valid_vec[i] = c_valid[i+1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && item_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_pop) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == CELL_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_acc && full) begin
				overflow_q <= 1'b1;
			end else if (last_pop) begin
				overflow_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_key_q      <= KEY_W'(c_key[1]);
			out_tag_q      <= c_tag[1];
			out_last_q     <= (count_q == CNT_W'(1));
			out_overflow_q <= overflow_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_key      = out_key_q;
	assign out_tag      = out_tag_q;
	assign out_last     = out_last_q;
	assign out_overflow = out_overflow_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("held count beyond capacity");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_vec)))
		else $error("held count disagrees with occupied cells");

	a_head_valid_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> c_valid[1])
		else $error("pop from an empty chain head");

	a_out_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_key) && $stable(out_tag)))
		else $error("stalled result changed");

endmodule

// File: bench/stable_record_sort_by_key_test.sv
`timescale 1ns / 100ps

module stable_record_sort_by_key_test;

	import srsk_pkg::*;

	localparam int CAPACITY = MAX_ITEMS_DEF;
	localparam logic [31:0] KEY_MASK = (32'd1 << KEY_BITS_DEF) - 32'd1;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 270;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		idle_mode_t       mode;
	} request_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} record_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             overflow;
	} sorted_rec_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic [KEY_W-1:0] item_key = '0;
	logic [TAG_W-1:0] item_tag = '0;
	logic             item_last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic             out_last;
	logic             out_overflow;

	request_t    request_q[$];
	record_t     held_recs[$];
	sorted_rec_t sorted_due[$];
	logic        batch_overflow = 1'b0;
	int          sent_cnt = 0;
	int          taken_cnt = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	idle_mode_t  cur_mode = IDLE_NONE;
	request_t    next_req;
	sorted_rec_t got_rec;
	sorted_rec_t want_rec;
	logic        moved;

	stable_record_sort_by_key u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item_key    (item_key),
		.item_tag    (item_tag),
		.item_last   (item_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_key     (out_key),
		.out_tag     (out_tag),
		.out_last    (out_last),
		.out_overflow(out_overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit idle_now(idle_mode_t mode, bit sender);
		int pct;
		pct = 0;
		if (mode == IDLE_BOTH)
			pct = 25;
		else if ((sender && mode == IDLE_SEND) || (!sender && mode == IDLE_RECV))
			pct = 67;
		return $urandom_range(0, 99) < pct;
	endfunction

	// store one accepted request; on the closing one emit the batch in stable key order
	function automatic void take_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
			logic last);
		record_t     order[$];
		record_t     rec;
		sorted_rec_t res;
		int          pos;
		rec.key = key & KEY_MASK[KEY_W-1:0];
		rec.tag = tag;
		if (held_recs.size() < CAPACITY)
			held_recs.push_back(rec);
		else
			batch_overflow = 1'b1;
		if (!last)
			return;
		foreach (held_recs[i]) begin
			pos = order.size();
			while (pos > 0 && order[pos-1].key > held_recs[i].key)
				pos--;
			order.insert(pos, held_recs[i]);
		end
		foreach (order[i]) begin
			res.key = order[i].key;
			res.tag = order[i].tag;
			res.last = (i == order.size() - 1);
			res.overflow = batch_overflow;
			sorted_due.push_back(res);
		end
		held_recs.delete();
		batch_overflow = 1'b0;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			if (!(item_valid && taken_cnt != sent_cnt)) begin
				if (request_q.size() != 0 && !idle_now(request_q[0].mode, 1'b1)) begin
					next_req = request_q.pop_front();
					cur_mode = next_req.mode;
					item_key <= next_req.key;
					item_tag <= next_req.tag;
					item_last <= next_req.last;
					item_valid <= 1'b1;
					sent_cnt++;
				end else begin
					item_valid <= 1'b0;
				end
			end
			out_stall <= idle_now(cur_mode, 1'b0);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (item_valid && !item_stall) begin
				take_request(item_key, item_tag, item_last);
				taken_cnt++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got_rec = '{out_key, out_tag, out_last, out_overflow};
				if (sorted_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: key %h tag %h last %b overflow %b",
							out_key, out_tag, out_last, out_overflow);
				end else begin
					want_rec = sorted_due.pop_front();
					if (got_rec.key !== want_rec.key || got_rec.tag !== want_rec.tag ||
							got_rec.last !== want_rec.last ||
							got_rec.overflow !== want_rec.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected key %h tag %h last %b overflow %b, got key %h tag %h last %b overflow %b",
								want_rec.key, want_rec.tag, want_rec.last, want_rec.overflow,
								got_rec.key, got_rec.tag, got_rec.last, got_rec.overflow);
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("stable_record_sort_by_key test failed");
				$finish;
			end
		end
	end

	function automatic void queue_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
			logic last, idle_mode_t mode);
		request_t req;
		req.key = key;
		req.tag = tag;
		req.last = last;
		req.mode = mode;
		request_q.push_back(req);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return KEY_W'($urandom_range(0, 3));
			1: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
			default: return KEY_W'($urandom);
		endcase
	endfunction

	initial begin
		int count;
		int batch;
		int size;
		logic [KEY_W-1:0] mixed[7];

		// single record batches at both key extremes
		queue_request(16'h0000, 16'hFFFF, 1'b1, IDLE_NONE);
		queue_request(16'hFFFF, 16'h0000, 1'b1, IDLE_NONE);
		// equal keys keep arrival order
		for (int i = 0; i < 5; i++)
			queue_request(16'h1234, TAG_W'(i + 1), i == 4, IDLE_NONE);
		// unordered keys with duplicates
		mixed = '{16'h0005, 16'h0003, 16'h0005, 16'h0003, 16'h0000, 16'hFFFF, 16'h0005};
		foreach (mixed[i])
			queue_request(mixed[i], TAG_W'(16'hA000 + i), i == 6, IDLE_NONE);

		count = 0;
		batch = 0;
		while (count < RANDOM_ITEMS) begin
			if (batch == 0)
				size = CAPACITY + 1;
			else if (batch == 1)
				size = CAPACITY;
			else if ($urandom_range(0, 24) == 0)
				size = $urandom_range(CAPACITY, CAPACITY + 4);
			else
				size = $urandom_range(1, 10);
			for (int i = 0; i < size; i++) begin
				queue_request(pick_key(), TAG_W'($urandom), i == size - 1,
					idle_mode_t'((count / 35) % 4));
				count++;
			end
			batch++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (request_q.size() != 0 || taken_cnt != sent_cnt || sorted_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && sorted_due.size() == 0)
			$display("stable_record_sort_by_key test passed");
		else
			$display("stable_record_sort_by_key test failed");
		$finish;
	end

endmodule
